/* hdl/clt_pkg.sv */
`default_nettype none
package clt_pkg;

	// Character codes the scanner reacts to
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;

	// Result kinds
	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_TOK_END = 2'd1;
	localparam logic [1:0] KIND_CMD_END = 2'd2;

	// Configuration register indexes
	localparam int unsigned REG_SEPARATOR_COUNT = 0;
	localparam int unsigned REG_SEPARATOR_BASE  = 1;

	localparam int unsigned CFG_DATA_W  = 8;
	localparam int unsigned SEP_COUNT_W = 3;
	localparam logic [SEP_COUNT_W-1:0] SEP_COUNT_RESET = 3'd1;

	// Results one input byte can cause, at most
	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned RIDX_W      = $clog2(MAX_RESULTS);
	localparam int unsigned RCNT_W      = $clog2(MAX_RESULTS + 1);

	// Queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       name;
		logic       empty;
	} res_t;

	typedef struct packed {
		res_t [MAX_RESULTS-1:0] res;
		logic [RCNT_W-1:0]      count;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_status_t;

	// Reset value of a separator slot
	function automatic logic [7:0] sep_reset_value(input int unsigned slot);
		logic [7:0] v;
		case (slot)
			0: v = 8'd32;
			1: v = 8'd9;
			2: v = 8'd10;
			3: v = 8'd13;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

	// Append one result to a bundle
	function automatic bundle_t bundle_push(input bundle_t bd, input res_t r);
		bundle_t o;
		o = bd;
		o.res[bd.count[RIDX_W-1:0]] = r;
		o.count = bd.count + RCNT_W'(1);
		return o;
	endfunction

	function automatic res_t mk_byte(input logic [7:0] b, input logic named);
		res_t r;
		r.kind  = KIND_BYTE;
		r.data  = b;
		r.name  = ~named;
		r.empty = 1'b0;
		return r;
	endfunction

	function automatic res_t mk_tok_end(input logic named, input logic has_bytes);
		res_t r;
		r.kind  = KIND_TOK_END;
		r.data  = 8'd0;
		r.name  = ~named;
		r.empty = ~has_bytes;
		return r;
	endfunction

	function automatic res_t mk_cmd_end();
		res_t r;
		r.kind  = KIND_CMD_END;
		r.data  = 8'd0;
		r.name  = 1'b0;
		r.empty = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

/* hdl/clt_front.sv */
`default_nettype none
module clt_front #(
	parameter int unsigned SEPARATOR_SLOTS = 4,
	parameter int unsigned CFG_INDEX_W = 3
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     accept,
	input  wire logic [7:0]               byte_in,
	input  wire logic                     final_byte,
	input  wire logic                     cfg_write,
	input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [clt_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          push,
	output clt_pkg::bundle_t              push_bundle
);

	typedef enum logic [2:0] {
		MODE_SKIP_PRE  = 3'd0,
		MODE_SKIP_POST = 3'd1,
		MODE_TOKEN     = 3'd2,
		MODE_QUOTE     = 3'd3,
		MODE_LINE      = 3'd4,
		MODE_BLOCK     = 3'd5
	} mode_t;

	mode_t mode_q;
	logic  slash_q;
	logic  star_q;
	logic  has_bytes_q;
	logic  named_q;

	logic [clt_pkg::SEP_COUNT_W-1:0] sep_count_q;
	logic [7:0]                      sep_q [SEPARATOR_SLOTS];

	mode_t            mode_d;
	logic             slash_d;
	logic             star_d;
	logic             has_bytes_d;
	logic             named_d;
	logic             is_sep;
	clt_pkg::bundle_t bd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_count_q <= clt_pkg::SEP_COUNT_RESET;
			for (int i = 0; i < SEPARATOR_SLOTS; i++) begin
				sep_q[i] <= clt_pkg::sep_reset_value(i);
			end
		end else if (cfg_write) begin
			if (cfg_index == CFG_INDEX_W'(clt_pkg::REG_SEPARATOR_COUNT)) begin
				sep_count_q <= cfg_data[clt_pkg::SEP_COUNT_W-1:0];
			end
			for (int i = 0; i < SEPARATOR_SLOTS; i++) begin
				if (cfg_index == CFG_INDEX_W'(clt_pkg::REG_SEPARATOR_BASE + i)) begin
					sep_q[i] <= cfg_data[7:0];
				end
			end
		end
	end

	// Match the byte against the active separator slots
	always_comb begin
		is_sep = 1'b0;
		for (int i = 0; i < SEPARATOR_SLOTS; i++) begin
			if ((4'(i) < {1'b0, sep_count_q}) && (sep_q[i] == byte_in)) begin
				is_sep = 1'b1;
			end
		end
	end

	// Classify the byte: collect its results and the next scanner state
	always_comb begin
		logic run_plain;
		mode_d      = mode_q;
		slash_d     = slash_q;
		star_d      = star_q;
		has_bytes_d = has_bytes_q;
		named_d     = named_q;
		bd          = '0;
		run_plain   = 1'b1;

		// resolve a held-back slash first
		if (slash_q) begin
			slash_d = 1'b0;
			if (byte_in == clt_pkg::CH_SLASH || byte_in == clt_pkg::CH_STAR) begin
				if (mode_q == MODE_TOKEN || mode_q == MODE_SKIP_POST) begin
					bd          = clt_pkg::bundle_push(bd, clt_pkg::mk_tok_end(named_d, has_bytes_d));
					named_d     = 1'b1;
					has_bytes_d = 1'b0;
				end
				mode_d    = (byte_in == clt_pkg::CH_SLASH) ? MODE_LINE : MODE_BLOCK;
				star_d    = 1'b0;
				run_plain = 1'b0;
			end else begin
				bd          = clt_pkg::bundle_push(bd, clt_pkg::mk_byte(clt_pkg::CH_SLASH, named_d));
				has_bytes_d = 1'b1;
				mode_d      = MODE_TOKEN;
			end
		end

		if (run_plain) begin
			case (mode_d)
				MODE_TOKEN: begin
					if (byte_in == clt_pkg::CH_QUOTE) begin
						mode_d = MODE_QUOTE;
					end else if (is_sep) begin
						bd          = clt_pkg::bundle_push(bd,
							clt_pkg::mk_tok_end(named_d, has_bytes_d));
						named_d     = 1'b1;
						has_bytes_d = 1'b0;
						mode_d      = MODE_SKIP_PRE;
					end else if (byte_in == clt_pkg::CH_SLASH && !final_byte) begin
						slash_d = 1'b1;
					end else begin
						bd          = clt_pkg::bundle_push(bd, clt_pkg::mk_byte(byte_in, named_d));
						has_bytes_d = 1'b1;
					end
				end
				MODE_QUOTE: begin
					if (byte_in == clt_pkg::CH_QUOTE) begin
						bd          = clt_pkg::bundle_push(bd,
							clt_pkg::mk_tok_end(named_d, has_bytes_d));
						named_d     = 1'b1;
						has_bytes_d = 1'b0;
						mode_d      = MODE_SKIP_PRE;
					end else begin
						bd          = clt_pkg::bundle_push(bd, clt_pkg::mk_byte(byte_in, named_d));
						has_bytes_d = 1'b1;
					end
				end
				MODE_LINE: begin
				end
				MODE_BLOCK: begin
					if (star_d && byte_in == clt_pkg::CH_SLASH) begin
						star_d = 1'b0;
						mode_d = MODE_SKIP_POST;
					end else begin
						star_d = (byte_in == clt_pkg::CH_STAR);
					end
				end
				default: begin
					// skipping separators; unknown codes fall back to before-comment
					if (mode_d != MODE_SKIP_POST) begin
						mode_d = MODE_SKIP_PRE;
					end
					if (is_sep) begin
					end else if (byte_in == clt_pkg::CH_SLASH && !final_byte) begin
						slash_d = 1'b1;
					end else if (byte_in == clt_pkg::CH_QUOTE) begin
						has_bytes_d = 1'b0;
						mode_d      = MODE_QUOTE;
					end else begin
						bd          = clt_pkg::bundle_push(bd, clt_pkg::mk_byte(byte_in, named_d));
						has_bytes_d = 1'b1;
						mode_d      = MODE_TOKEN;
					end
				end
			endcase
		end

		// close the command on its last byte
		if (final_byte) begin
			if (has_bytes_d) begin
				bd = clt_pkg::bundle_push(bd, clt_pkg::mk_tok_end(named_d, has_bytes_d));
			end
			bd          = clt_pkg::bundle_push(bd, clt_pkg::mk_cmd_end());
			mode_d      = MODE_SKIP_PRE;
			slash_d     = 1'b0;
			star_d      = 1'b0;
			has_bytes_d = 1'b0;
			named_d     = 1'b0;
		end
	end

	assign push        = accept && (bd.count != '0);
	assign push_bundle = bd;

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SKIP_PRE;
			slash_q     <= 1'b0;
			star_q      <= 1'b0;
			has_bytes_q <= 1'b0;
			named_q     <= 1'b0;
		end else if (accept) begin
			mode_q      <= mode_d;
			slash_q     <= slash_d;
			star_q      <= star_d;
			has_bytes_q <= has_bytes_d;
			named_q     <= named_d;
		end
	end

endmodule
`default_nettype wire

/* hdl/clt_queue.sv */
`default_nettype none
module clt_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire clt_pkg::bundle_t  push_bundle,
	input  wire logic              pop,
	output clt_pkg::bundle_t       head,
	output clt_pkg::q_status_t     status
);

	clt_pkg::bundle_t                 mem_q [clt_pkg::QUEUE_DEPTH];
	logic [clt_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [clt_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [clt_pkg::QCNT_W-1:0]       count_q;

	function automatic logic [clt_pkg::QPTR_W-1:0] ptr_next(
		input logic [clt_pkg::QPTR_W-1:0] p);
		logic [clt_pkg::QPTR_W-1:0] n;
		if (p == clt_pkg::QPTR_W'(clt_pkg::QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + clt_pkg::QPTR_W'(1);
		end
		return n;
	endfunction

	assign head            = mem_q[rd_ptr_q];
	assign status.full     = (count_q == clt_pkg::QCNT_W'(clt_pkg::QUEUE_DEPTH));
	assign status.nonempty = (count_q != '0);

	// Store pushed bundles
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_bundle;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + clt_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - clt_pkg::QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/clt_back.sv */
`default_nettype none
module clt_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire clt_pkg::bundle_t    head,
	input  wire clt_pkg::q_status_t  status,
	output logic                     pop,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic [1:0]               kind,
	output logic [7:0]               byte_out,
	output logic                     is_name,
	output logic                     token_empty,
	output logic                     run_last
);

	logic [clt_pkg::RIDX_W-1:0] idx_q;
	logic                       valid_q;
	clt_pkg::res_t              res_q;
	logic                       last_q;

	logic          load;
	logic          take;
	logic          is_last;
	clt_pkg::res_t cur;

	assign load    = !valid_q || !result_stall;
	assign take    = load && status.nonempty;
	assign cur     = head.res[idx_q];
	assign is_last = ({1'b0, idx_q} + clt_pkg::RCNT_W'(1)) == head.count;
	assign pop     = take && is_last;

	// Walk through the head bundle, one result per cycle while not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= status.nonempty;
			if (take) begin
				idx_q <= is_last ? '0 : idx_q + clt_pkg::RIDX_W'(1);
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (take) begin
			res_q  <= cur;
			last_q <= is_last;
		end
	end

	assign result_valid = valid_q;
	assign kind         = res_q.kind;
	assign byte_out     = res_q.data;
	assign is_name      = res_q.name;
	assign token_empty  = res_q.empty;
	assign run_last     = last_q;

endmodule
`default_nettype wire

/* hdl/command_line_tokenizer.sv */
`default_nettype none
// Command line tokenizer. Takes one command character per transaction, with
// final_byte on the last one, and returns token bytes, token ends (with the
// name and empty flags) and a command end; run_last marks the last result of
// each input byte. A byte is accepted in the cycle it arrives as long as the
// two-entry bundle queue between the classifying front and the emitting back
// has room; its first result passes through the queue and the output register,
// which issues one result per cycle unless stalled. A byte has at most four
// results, and bytes with one result or none sustain one byte per cycle when
// unstalled. Separator registers are written via cfg_write/cfg_index/cfg_data
// while the block is idle, a rule for the user, not enforced by the block:
// index 0 is the slot count, 1 to SEPARATOR_SLOTS the separator characters.
module command_line_tokenizer #(
	parameter int unsigned SEPARATOR_SLOTS = 4,
	localparam int unsigned CFG_INDEX_W = $clog2(SEPARATOR_SLOTS + 1)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           byte_valid,
	output logic                                byte_stall,
	input  wire logic [7:0]                     byte_in,
	input  wire logic                           final_byte,
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output logic [1:0]                          kind,
	output logic [7:0]                          byte_out,
	output logic                                is_name,
	output logic                                token_empty,
	output logic                                run_last,
	input  wire logic                           cfg_write,
	input  wire logic [CFG_INDEX_W-1:0]         cfg_index,
	input  wire logic [clt_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic               accept;
	logic               push;
	logic               pop;
	clt_pkg::bundle_t   push_bundle;
	clt_pkg::bundle_t   head;
	clt_pkg::q_status_t status;

	assign byte_stall = status.full;
	assign accept     = byte_valid && !status.full;

	clt_front #(
		.SEPARATOR_SLOTS(SEPARATOR_SLOTS),
		.CFG_INDEX_W(CFG_INDEX_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.byte_in(byte_in),
		.final_byte(final_byte),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.push_bundle(push_bundle)
	);

	clt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_bundle(push_bundle),
		.pop(pop),
		.head(head),
		.status(status)
	);

	clt_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.status(status),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.byte_out(byte_out),
		.is_name(is_name),
		.token_empty(token_empty),
		.run_last(run_last)
	);

endmodule
`default_nettype wire

/* verif/clt_checker.sv */
`default_nettype none
module clt_checker #(
	parameter int unsigned INDEX_W = 3
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	input  wire logic               byte_stall,
	input  wire logic [7:0]         byte_in,
	input  wire logic               final_byte,
	input  wire logic               result_valid,
	input  wire logic               result_stall,
	input  wire logic [1:0]         kind,
	input  wire logic [7:0]         byte_out,
	input  wire logic               is_name,
	input  wire logic               token_empty,
	input  wire logic               run_last,
	input  wire logic               cfg_write,
	input  wire logic [INDEX_W-1:0] cfg_index,
	input  wire logic [7:0]         cfg_data,
	output int                      mismatches,
	output int                      outstanding,
	output int                      results_checked,
	output int                      token_ends
);

	localparam int SLOTS = 4;

	typedef enum logic [2:0] {
		SCAN_SKIP_PRE,
		SCAN_SKIP_POST,
		SCAN_TOKEN,
		SCAN_QUOTE,
		SCAN_LINE,
		SCAN_BLOCK
	} scan_mode_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       name;
		logic       empty;
		logic       last;
	} token_result_t;

	token_result_t expected_results[$];
	token_result_t byte_results[$];

	// Separator configuration as the block should hold it
	logic [2:0] sep_count;
	logic [7:0] sep_char [SLOTS];

	// Scanner state of the command in progress
	scan_mode_t mode;
	logic       slash_held;
	logic       star_prev;
	logic       token_filled;
	logic       name_ended;

	int fail_tally;
	int checked_tally;
	int tok_end_tally;

	function automatic logic is_separator(input logic [7:0] b);
		int n;
		n = int'(sep_count);
		if (n > SLOTS)
			n = SLOTS;
		for (int i = 0; i < n; i++)
			if (sep_char[i] == b)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void push_result(input logic [1:0] k, input logic [7:0] d,
			input logic nm, input logic em);
		token_result_t r;
		r.kind  = k;
		r.data  = d;
		r.name  = nm;
		r.empty = em;
		r.last  = 1'b0;
		byte_results.push_back(r);
	endfunction

	function automatic void emit_char(input logic [7:0] b);
		push_result(clt_pkg::KIND_BYTE, b, !name_ended, 1'b0);
		token_filled = 1'b1;
	endfunction

	function automatic void close_token();
		push_result(clt_pkg::KIND_TOK_END, 8'd0, !name_ended, !token_filled);
		name_ended   = 1'b1;
		token_filled = 1'b0;
	endfunction

	function automatic void clear_command();
		mode         = SCAN_SKIP_PRE;
		slash_held   = 1'b0;
		star_prev    = 1'b0;
		token_filled = 1'b0;
		name_ended   = 1'b0;
	endfunction

	// Handle one byte with no slash held back
	function automatic void scan_plain(input logic [7:0] b, input logic fin);
		case (mode)
			SCAN_TOKEN: begin
				if (b == clt_pkg::CH_QUOTE)
					mode = SCAN_QUOTE;
				else if (is_separator(b)) begin
					close_token();
					mode = SCAN_SKIP_PRE;
				end else if (b == clt_pkg::CH_SLASH && !fin)
					slash_held = 1'b1;
				else
					emit_char(b);
			end
			SCAN_QUOTE: begin
				if (b == clt_pkg::CH_QUOTE) begin
					close_token();
					mode = SCAN_SKIP_PRE;
				end else
					emit_char(b);
			end
			SCAN_LINE: ;
			SCAN_BLOCK: begin
				if (star_prev && b == clt_pkg::CH_SLASH) begin
					star_prev = 1'b0;
					mode = SCAN_SKIP_POST;
				end else
					star_prev = (b == clt_pkg::CH_STAR);
			end
			default: begin
				// between tokens; unused codes behave as skipping before a comment
				if (mode != SCAN_SKIP_POST)
					mode = SCAN_SKIP_PRE;
				if (!is_separator(b)) begin
					if (b == clt_pkg::CH_SLASH && !fin)
						slash_held = 1'b1;
					else if (b == clt_pkg::CH_QUOTE) begin
						token_filled = 1'b0;
						mode = SCAN_QUOTE;
					end else begin
						emit_char(b);
						mode = SCAN_TOKEN;
					end
				end
			end
		endcase
	endfunction

	// Work out every result one accepted byte causes and queue them
	function automatic void predict_byte(input logic [7:0] b, input logic fin);
		token_result_t tail;
		byte_results.delete();
		if (slash_held) begin
			slash_held = 1'b0;
			if (b == clt_pkg::CH_SLASH || b == clt_pkg::CH_STAR) begin
				if (mode == SCAN_TOKEN || mode == SCAN_SKIP_POST)
					close_token();
				mode = (b == clt_pkg::CH_SLASH) ? SCAN_LINE : SCAN_BLOCK;
				star_prev = 1'b0;
			end else begin
				emit_char(clt_pkg::CH_SLASH);
				mode = SCAN_TOKEN;
				scan_plain(b, fin);
			end
		end else
			scan_plain(b, fin);

		if (fin) begin
			if (token_filled)
				close_token();
			push_result(clt_pkg::KIND_CMD_END, 8'd0, 1'b0, 1'b0);
			clear_command();
		end

		if (byte_results.size() > 0) begin
			tail = byte_results.pop_back();
			tail.last = 1'b1;
			byte_results.push_back(tail);
		end
		foreach (byte_results[i])
			expected_results.push_back(byte_results[i]);
	endfunction

	function automatic void note_mismatch(input string field, input int want, input int got);
		fail_tally++;
		$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
	endfunction

	// Compare one accepted result with the oldest expectation
	function automatic void check_result();
		token_result_t want;
		token_result_t got;
		got = {kind, byte_out, is_name, token_empty, run_last};
		if (expected_results.size() == 0) begin
			fail_tally++;
			$display("%0t: unexpected result, expected none, got kind %0d byte %0d",
				$time, kind, byte_out);
			return;
		end
		want = expected_results.pop_front();
		checked_tally++;
		if (want.kind == clt_pkg::KIND_TOK_END)
			tok_end_tally++;
		if (got.kind !== want.kind)
			note_mismatch("kind", int'(want.kind), int'(got.kind));
		if (got.data !== want.data)
			note_mismatch("byte_out", int'(want.data), int'(got.data));
		if (got.name !== want.name)
			note_mismatch("is_name", int'(want.name), int'(got.name));
		if (got.empty !== want.empty)
			note_mismatch("token_empty", int'(want.empty), int'(got.empty));
		if (got.last !== want.last)
			note_mismatch("run_last", int'(want.last), int'(got.last));
	endfunction

	// Track configuration, predict and compare on every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_count   = clt_pkg::SEP_COUNT_RESET;
			sep_char[0] = 8'd32;
			sep_char[1] = 8'd9;
			sep_char[2] = 8'd10;
			sep_char[3] = 8'd13;
			clear_command();
			expected_results.delete();
			fail_tally    = 0;
			checked_tally = 0;
			tok_end_tally = 0;
			mismatches      <= 0;
			outstanding     <= 0;
			results_checked <= 0;
			token_ends      <= 0;
		end else begin
			if (result_valid && !result_stall)
				check_result();
			if (byte_valid && !byte_stall)
				predict_byte(byte_in, final_byte);
			if (cfg_write) begin
				if (int'(cfg_index) == clt_pkg::REG_SEPARATOR_COUNT)
					sep_count = cfg_data[2:0];
				else if (int'(cfg_index) >= clt_pkg::REG_SEPARATOR_BASE &&
						int'(cfg_index) < clt_pkg::REG_SEPARATOR_BASE + SLOTS)
					sep_char[int'(cfg_index) - clt_pkg::REG_SEPARATOR_BASE] = cfg_data;
			end
			mismatches      <= fail_tally;
			outstanding     <= expected_results.size();
			results_checked <= checked_tally;
			token_ends      <= tok_end_tally;
		end
	end

endmodule
`default_nettype wire

/* verif/tb_command_line_tokenizer.sv */
`default_nettype none
module tb_command_line_tokenizer;

	localparam int RANDOM_ITEMS = 360;
	localparam int PHASES       = 6;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 16;
	localparam int INDEX_W      = 3;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               byte_valid   = 1'b0;
	logic [7:0]         byte_in      = 8'd0;
	logic               final_byte   = 1'b0;
	logic               result_stall = 1'b0;
	logic               cfg_write    = 1'b0;
	logic [INDEX_W-1:0] cfg_index    = '0;
	logic [7:0]         cfg_data     = 8'd0;

	logic       byte_stall;
	logic       result_valid;
	logic [1:0] kind;
	logic [7:0] byte_out;
	logic       is_name;
	logic       token_empty;
	logic       run_last;

	int mismatches;
	int outstanding;
	int results_checked;
	int token_ends;

	logic [7:0] cmd_text[$];
	logic [7:0] active_seps[$];
	bit         steady       = 1'b0;
	bit         hold_request = 1'b0;
	int         cycle_count  = 0;
	int         commands_sent = 0;
	int         items_sent    = 0;
	int         settings_used = 0;

	command_line_tokenizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_in      (byte_in),
		.final_byte   (final_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.byte_out     (byte_out),
		.is_name      (is_name),
		.token_empty  (token_empty),
		.run_last     (run_last),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	clt_checker #(.INDEX_W(INDEX_W)) token_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.byte_in         (byte_in),
		.final_byte      (final_byte),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.kind            (kind),
		.byte_out        (byte_out),
		.is_name         (is_name),
		.token_empty     (token_empty),
		.run_last        (run_last),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.token_ends      (token_ends)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Give up if the run hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 60)
			return 0;
		if (r < 92)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(8, 30));
	endfunction

	// Receiver: random stalls, one long hold-off on request
	initial begin
		int stall_len;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!steady) begin
				stall_len = idle_gap();
				if (stall_len > 0) begin
					result_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
				end
			end
			result_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = steady ? 0 : idle_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_in    <= b;
		final_byte <= fin;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_command();
		foreach (cmd_text[i])
			send_byte(cmd_text[i], i == cmd_text.size() - 1);
		commands_sent++;
	endtask

	// Drain the block, then rewrite every separator register
	task automatic set_separators(input logic [2:0] cnt, input logic [7:0] s0,
			input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] s3);
		logic [7:0] slot [4];
		slot[0] = s0;
		slot[1] = s1;
		slot[2] = s2;
		slot[3] = s3;
		byte_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= INDEX_W'(clt_pkg::REG_SEPARATOR_COUNT);
		cfg_data  <= 8'(cnt);
		@(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_index <= INDEX_W'(clt_pkg::REG_SEPARATOR_BASE + i);
			cfg_data  <= slot[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		active_seps.delete();
		for (int i = 0; i < 4 && i < int'(cnt); i++)
			active_seps.push_back(slot[i]);
		settings_used++;
	endtask

	function automatic logic [7:0] pick_separator();
		if (active_seps.size() == 0)
			return " ";
		return active_seps[$urandom_range(0, active_seps.size() - 1)];
	endfunction

	function automatic logic [7:0] pick_letter();
		return 8'($urandom_range(97, 122));
	endfunction

	function automatic logic [7:0] pick_printable();
		return 8'($urandom_range(32, 126));
	endfunction

	// Assemble a mostly well-formed command from random pieces
	task automatic build_command(input int pieces);
		int n;
		cmd_text.delete();
		for (int p = 0; p < pieces; p++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					n = int'($urandom_range(1, 5));
					repeat (n) cmd_text.push_back(pick_letter());
				end
				3, 4: begin
					n = int'($urandom_range(1, 3));
					repeat (n) cmd_text.push_back(pick_separator());
				end
				5: begin
					cmd_text.push_back(clt_pkg::CH_QUOTE);
					n = int'($urandom_range(0, 4));
					repeat (n) cmd_text.push_back(pick_printable());
					if ($urandom_range(0, 4) != 0)
						cmd_text.push_back(clt_pkg::CH_QUOTE);
				end
				6: begin
					cmd_text.push_back(clt_pkg::CH_SLASH);
					cmd_text.push_back(clt_pkg::CH_SLASH);
					n = int'($urandom_range(0, 4));
					repeat (n) cmd_text.push_back(pick_printable());
				end
				7: begin
					cmd_text.push_back(clt_pkg::CH_SLASH);
					cmd_text.push_back(clt_pkg::CH_STAR);
					n = int'($urandom_range(0, 5));
					repeat (n)
						cmd_text.push_back(($urandom_range(0, 2) == 0) ? clt_pkg::CH_STAR
							: pick_printable());
					if ($urandom_range(0, 9) != 0) begin
						cmd_text.push_back(clt_pkg::CH_STAR);
						cmd_text.push_back(clt_pkg::CH_SLASH);
					end
				end
				8: begin
					cmd_text.push_back(clt_pkg::CH_SLASH);
					cmd_text.push_back(pick_letter());
				end
				default: begin
					n = int'($urandom_range(1, 3));
					repeat (n) cmd_text.push_back(8'($urandom_range(0, 255)));
				end
			endcase
		end
		if (cmd_text.size() == 0)
			cmd_text.push_back(pick_letter());
	endtask

	initial begin
		int phase_items;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		active_seps.push_back(8'd32);

		// second comment between tokens flushes an empty name token
		cmd_text = '{clt_pkg::CH_SLASH, clt_pkg::CH_STAR, clt_pkg::CH_STAR,
			clt_pkg::CH_SLASH, clt_pkg::CH_SLASH, clt_pkg::CH_SLASH, "x"};
		send_command();
		// empty quotes, extreme bytes, quote left open at the end
		cmd_text = '{clt_pkg::CH_QUOTE, clt_pkg::CH_QUOTE, 8'h00, clt_pkg::CH_QUOTE, 8'hFF};
		send_command();
		// slash followed by a letter, and slash as the final byte
		cmd_text = '{"a", clt_pkg::CH_SLASH, "b", " ", clt_pkg::CH_SLASH};
		send_command();
		// quote and slash both as separators
		set_separators(3'd2, clt_pkg::CH_QUOTE, clt_pkg::CH_SLASH, ",", ";");
		cmd_text = '{clt_pkg::CH_QUOTE, "a", clt_pkg::CH_SLASH, clt_pkg::CH_SLASH, "b",
			clt_pkg::CH_QUOTE, "c"};
		send_command();

		// random commands under a series of separator settings
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_separators(3'd4, " ", 8'd9, ",", ";");
				1: set_separators(3'd0, " ", 8'd9, 8'd10, 8'd13);
				2: set_separators(3'd7, 8'h00, 8'hFF, " ", clt_pkg::CH_QUOTE);
				3: set_separators(3'd3, " ", clt_pkg::CH_SLASH, clt_pkg::CH_STAR, "=");
				4: set_separators(3'd1, 8'd32, 8'd9, 8'd10, 8'd13);
				default: set_separators(3'($urandom_range(0, 7)), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			phase_items = 0;
			if (ph == 0) begin
				// hold the receiver off while the sender keeps pushing
				steady = 1'b1;
				hold_request = 1'b1;
				build_command(20);
				send_command();
				phase_items += cmd_text.size();
				steady = 1'b0;
			end
			while (phase_items < RANDOM_ITEMS / PHASES) begin
				steady = ($urandom_range(0, 4) == 0);
				build_command(int'($urandom_range(1, 8)));
				send_command();
				phase_items += cmd_text.size();
			end
			steady = 1'b0;
		end

		byte_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Tokenised %0d commands (%0d bytes) under %0d separator settings",
			commands_sent, items_sent, settings_used);
		$display("Compared %0d results, %0d of them token ends; %0d mismatches",
			results_checked, token_ends, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
